// File: rtl/usb_device_request_responder_macros.svh
// ---------------------------------------------------------------------------
// usb_device_request_responder_macros.svh
// Assertion macros shared by the responder's checker.
// ---------------------------------------------------------------------------
`ifndef USB_DEVICE_REQUEST_RESPONDER_MACROS_SVH
`define USB_DEVICE_REQUEST_RESPONDER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define USBDR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define USBDR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/usbdr_pkg.sv
// ---------------------------------------------------------------------------
// usbdr_pkg
// Types, codes, descriptor ROM and reset values for the EP0 responder.
// ---------------------------------------------------------------------------
package usbdr_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned REG_W       = 16;

  localparam logic [15:0] VENDOR_ID_RST      = 16'hdead;
  localparam logic [15:0] PRODUCT_ID_RST     = 16'hbeef;
  localparam logic [15:0] DEVICE_RELEASE_RST = 16'h1138;

  // hub-style port bits
  localparam int unsigned ST_CONN_BIT     = 0;
  localparam int unsigned ST_ENABLE_BIT   = 1;
  localparam int unsigned ST_RESET_BIT    = 4;
  localparam int unsigned ST_POWER_BIT    = 8;
  localparam int unsigned CH_CONN_BIT     = 0;
  localparam int unsigned CH_RESET_BIT    = 4;
  localparam int unsigned FL_RESUMING_BIT = 0;

  localparam logic [7:0] PORT_ONE = 8'd1;

  localparam logic [7:0] RT_STD_OUT_DEV = 8'h00;
  localparam logic [7:0] RT_STD_IN_DEV  = 8'h80;

  localparam logic [7:0] RQ_SET_ADDRESS       = 8'd5;
  localparam logic [7:0] RQ_GET_DESC          = 8'd6;
  localparam logic [7:0] RQ_SET_CONFIGURATION = 8'd9;
  localparam logic [7:0] RQ_SET_INTERFACE     = 8'd11;

  localparam logic [7:0] DT_DEVICE = 8'd1;
  localparam logic [7:0] DT_CONFIG = 8'd2;
  localparam logic [7:0] DT_STRING = 8'd3;

  localparam logic [4:0] LEN_DEVICE = 5'd18;
  localparam logic [4:0] LEN_CONFIG = 5'd18;
  localparam logic [4:0] LEN_STR0   = 5'd4;
  localparam logic [4:0] LEN_STR1   = 5'd26;

  typedef enum logic [2:0] {
    OUT_SUCCESS   = 3'd0,
    OUT_STALL     = 3'd1,
    OUT_NOT_ADDR  = 3'd2,
    OUT_NOT_CTRL  = 3'd3,
    OUT_BAD_PORT  = 3'd4,
    OUT_PORT_DONE = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    DESC_NONE   = 3'd0,
    DESC_DEVICE = 3'd1,
    DESC_CONFIG = 3'd2,
    DESC_STR0   = 3'd3,
    DESC_STR1   = 3'd4
  } desc_t;

  typedef enum logic [1:0] {
    CFG_VENDOR_ID      = 2'd0,
    CFG_PRODUCT_ID     = 2'd1,
    CFG_DEVICE_RELEASE = 2'd2
  } cfg_idx_t;

  // classified request handed from front to back
  typedef struct packed {
    outcome_t   outcome;
    logic       do_connect;
    logic       do_reset_done;
    logic       do_resume;
    desc_t      desc;
    logic [4:0] len;
    logic [6:0] addr;
    logic       addr_valid;
  } cmd_t;

  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] device_release;
  } desc_cfg_t;

  localparam logic [7:0] ROM_DEV [18] = '{
    8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd64, 8'had, 8'hde,
    8'hef, 8'hbe, 8'h38, 8'h11, 8'd0, 8'd1, 8'd0, 8'd1};
  localparam logic [7:0] ROM_CONF [18] = '{
    8'd9, 8'd2, 8'd18, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd0, 8'd9,
    8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] ROM_STR0 [4] = '{8'h04, 8'h03, 8'h09, 8'h04};
  // "Hello World!" in UTF-16LE
  localparam logic [7:0] ROM_STR1 [26] = '{
    8'h1a, 8'h03, 8'h48, 8'h00, 8'h65, 8'h00, 8'h6c, 8'h00, 8'h6c, 8'h00,
    8'h6f, 8'h00, 8'h20, 8'h00, 8'h57, 8'h00, 8'h6f, 8'h00, 8'h72, 8'h00,
    8'h6c, 8'h00, 8'h64, 8'h00, 8'h21, 8'h00};

  function automatic logic [7:0] desc_byte(desc_t d, logic [4:0] i, desc_cfg_t c);
    logic [7:0] b;
    b = 8'd0;
    case (d)
      DESC_DEVICE: begin
        case (i)
          5'd8:    b = c.vendor_id[7:0];
          5'd9:    b = c.vendor_id[15:8];
          5'd10:   b = c.product_id[7:0];
          5'd11:   b = c.product_id[15:8];
          5'd12:   b = c.device_release[7:0];
          5'd13:   b = c.device_release[15:8];
          default: b = ROM_DEV[i];
        endcase
      end
      DESC_CONFIG: b = ROM_CONF[i];
      DESC_STR0:   b = ROM_STR0[i[1:0]];
      DESC_STR1:   b = ROM_STR1[i];
      default:     b = 8'd0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/usbdr_front.sv
// ---------------------------------------------------------------------------
// usbdr_front
// Accepts port events and requests, keeps address and port history,
// and classifies each item into a command for the back end.
// ---------------------------------------------------------------------------
module usbdr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              in_func,
  input  logic [7:0]        in_port_index,
  input  logic [15:0]       in_port_status,
  input  logic [15:0]       in_port_change,
  input  logic [7:0]        in_port_flags,
  input  logic [6:0]        in_target_address,
  input  logic              in_is_control,
  input  logic [7:0]        in_endpoint_address,
  input  logic [7:0]        in_request_type,
  input  logic [7:0]        in_request_code,
  input  logic [15:0]       in_setup_value,
  input  logic [15:0]       in_requested_length,
  output usbdr_pkg::cmd_t   cmd
);
  import usbdr_pkg::*;

  logic [6:0]  dev_addr_r, dev_addr_nxt;
  logic        addr_valid_r, addr_valid_nxt;
  logic [15:0] last_status_r, last_status_nxt;
  logic [7:0]  last_flags_r, last_flags_nxt;

  desc_t       desc;
  logic [4:0]  dlen;
  logic [7:0]  dtype;
  logic [7:0]  dindex;

  always_comb begin
    dtype  = in_setup_value[15:8];
    dindex = in_setup_value[7:0];
    desc   = DESC_NONE;
    dlen   = 5'd0;
    if (in_request_type == RT_STD_IN_DEV && in_request_code == RQ_GET_DESC) begin
      if (dtype == DT_DEVICE) begin
        desc = DESC_DEVICE;
        dlen = LEN_DEVICE;
      end else if (dtype == DT_CONFIG) begin
        desc = DESC_CONFIG;
        dlen = LEN_CONFIG;
      end else if (dtype == DT_STRING && dindex == 8'd0) begin
        desc = DESC_STR0;
        dlen = LEN_STR0;
      end else if (dtype == DT_STRING && dindex == 8'd1) begin
        desc = DESC_STR1;
        dlen = LEN_STR1;
      end
    end
  end

  always_comb begin
    dev_addr_nxt    = dev_addr_r;
    addr_valid_nxt  = addr_valid_r;
    last_status_nxt = last_status_r;
    last_flags_nxt  = last_flags_r;
    cmd             = '0;
    cmd.outcome     = OUT_STALL;
    cmd.desc        = DESC_NONE;

    if (!in_func) begin
      if (in_port_index != PORT_ONE) begin
        cmd.outcome = OUT_BAD_PORT;
      end else begin
        cmd.outcome     = OUT_PORT_DONE;
        last_status_nxt = in_port_status;
        last_flags_nxt  = in_port_flags;
        if (in_port_change[CH_CONN_BIT]) begin
          addr_valid_nxt = 1'b0;
          dev_addr_nxt   = 7'd0;
        end
        // reset finished with the port enabled: default address
        if (in_port_change[CH_RESET_BIT] && !in_port_status[ST_RESET_BIT] &&
            in_port_status[ST_ENABLE_BIT]) begin
          addr_valid_nxt = 1'b1;
          dev_addr_nxt   = 7'd0;
        end
        cmd.do_connect    = !last_status_r[ST_POWER_BIT] && in_port_status[ST_POWER_BIT];
        cmd.do_reset_done = !last_status_r[ST_RESET_BIT] && in_port_status[ST_RESET_BIT] &&
                            in_port_status[ST_CONN_BIT];
        cmd.do_resume     = !last_flags_r[FL_RESUMING_BIT] &&
                            in_port_flags[FL_RESUMING_BIT] && in_port_status[ST_CONN_BIT];
      end
    end else if (!addr_valid_r || in_target_address != dev_addr_r) begin
      cmd.outcome = OUT_NOT_ADDR;
    end else if (!in_is_control) begin
      cmd.outcome = OUT_NOT_CTRL;
    end else if (in_endpoint_address[6:0] != 7'd0) begin
      cmd.outcome = OUT_STALL;
    end else if (in_request_type == RT_STD_OUT_DEV && in_request_code == RQ_SET_ADDRESS) begin
      if (in_setup_value > 16'h007f) begin
        cmd.outcome = OUT_STALL;
      end else begin
        cmd.outcome    = OUT_SUCCESS;
        dev_addr_nxt   = in_setup_value[6:0];
        addr_valid_nxt = 1'b1;
      end
    end else if (in_request_type == RT_STD_OUT_DEV &&
                 (in_request_code == RQ_SET_CONFIGURATION ||
                  in_request_code == RQ_SET_INTERFACE)) begin
      cmd.outcome = OUT_SUCCESS;
    end else if (desc != DESC_NONE) begin
      cmd.outcome = OUT_SUCCESS;
      cmd.desc    = desc;
      cmd.len     = (in_requested_length < {11'd0, dlen}) ? in_requested_length[4:0] : dlen;
    end

    cmd.addr_valid = addr_valid_nxt;
    cmd.addr       = addr_valid_nxt ? dev_addr_nxt : 7'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= 7'd0;
      addr_valid_r  <= 1'b0;
      last_status_r <= 16'd0;
      last_flags_r  <= 8'd0;
    end else if (accept) begin
      dev_addr_r    <= dev_addr_nxt;
      addr_valid_r  <= addr_valid_nxt;
      last_status_r <= last_status_nxt;
      last_flags_r  <= last_flags_nxt;
    end
  end

endmodule

// File: rtl/usbdr_cmd_queue.sv
// ---------------------------------------------------------------------------
// usbdr_cmd_queue
// Small FIFO of classified commands between front and back.
// ---------------------------------------------------------------------------
module usbdr_cmd_queue #(
  parameter int unsigned DEPTH = usbdr_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  usbdr_pkg::cmd_t wr_cmd,
  output logic            full,
  output logic            rd_valid,
  input  logic            rd_pop,
  output usbdr_pkg::cmd_t rd_cmd
);
  import usbdr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign rd_cmd   = mem_r[rd_ptr_r];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_pop && rd_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    if (do_rd) rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    if (do_wr && !do_rd) cnt_nxt = cnt_r + CNT_W'(1);
    else if (do_rd && !do_wr) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wr_cmd;
  end

endmodule

// File: rtl/usbdr_back.sv
// ---------------------------------------------------------------------------
// usbdr_back
// Carries out queued commands: one result per cycle into the output register
// while it is free or popped, walking descriptor bytes for descriptor reads.
// ---------------------------------------------------------------------------
module usbdr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cmd_valid,
  input  usbdr_pkg::cmd_t      cmd,
  output logic                 cmd_pop,
  input  usbdr_pkg::desc_cfg_t dcfg,
  output logic                 empty,
  input  logic                 pop,
  output logic [2:0]           out_outcome,
  output logic [7:0]           out_data_byte,
  output logic                 out_byte_valid,
  output logic                 out_last,
  output logic [4:0]           out_actual_length,
  output logic                 out_do_connect,
  output logic                 out_do_reset_done,
  output logic                 out_do_resume,
  output logic [6:0]           out_current_address,
  output logic                 out_address_valid
);
  import usbdr_pkg::*;

  logic       valid_r, valid_nxt;
  logic [4:0] idx_r, idx_nxt;
  logic       single, is_last, adv;

  outcome_t   outcome_r;
  logic [7:0] byte_r;
  logic       bv_r, last_r;
  logic [4:0] alen_r;
  logic       con_r, rd_r, res_r;
  logic [6:0] addr_r;
  logic       addr_valid_r;

  // everything but a non-empty descriptor is a single result
  assign single  = (cmd.desc == DESC_NONE) || (cmd.len == 5'd0);
  assign is_last = single || ((idx_r + 5'd1) == cmd.len);
  assign adv     = cmd_valid && (!valid_r || pop);
  assign cmd_pop = adv && is_last;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (adv) begin
      valid_nxt = 1'b1;
      idx_nxt   = is_last ? 5'd0 : idx_r + 5'd1;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 5'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      outcome_r    <= cmd.outcome;
      byte_r       <= single ? 8'd0 : desc_byte(cmd.desc, idx_r, dcfg);
      bv_r         <= !single;
      last_r       <= is_last;
      alen_r       <= single ? 5'd0 : cmd.len;
      con_r        <= cmd.do_connect;
      rd_r         <= cmd.do_reset_done;
      res_r        <= cmd.do_resume;
      addr_r       <= cmd.addr;
      addr_valid_r <= cmd.addr_valid;
    end
  end

  assign empty               = !valid_r;
  assign out_outcome         = outcome_r;
  assign out_data_byte       = byte_r;
  assign out_byte_valid      = bv_r;
  assign out_last            = last_r;
  assign out_actual_length   = alen_r;
  assign out_do_connect      = con_r;
  assign out_do_reset_done   = rd_r;
  assign out_do_resume       = res_r;
  assign out_current_address = addr_r;
  assign out_address_valid   = addr_valid_r;

endmodule

// File: rtl/usb_device_request_responder.sv
// ---------------------------------------------------------------------------
// usb_device_request_responder
// USB endpoint-0 responder for one full-speed port.
// ---------------------------------------------------------------------------
// The front end takes one item (port event or request) per cycle whenever
// full is low, updates the device address and port history at once, and
// queues a classified command. The back end turns each command into its
// results at one per cycle while the result side is not stalled: a single
// result for events and most requests, or one result per descriptor byte
// (up to 26) for a descriptor read. With the back end idle, an accepted
// item passes through the command queue and the output register before
// its first result is on the ports. The command queue (QUEUE_DEPTH
// entries) lets input continue while a long descriptor drains or the
// result side stalls.
// ---------------------------------------------------------------------------
module usb_device_request_responder #(
  parameter int unsigned QUEUE_DEPTH = usbdr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_func,
  input  logic [7:0]  in_port_index,
  input  logic [15:0] in_port_status,
  input  logic [15:0] in_port_change,
  input  logic [7:0]  in_port_flags,
  input  logic [6:0]  in_target_address,
  input  logic        in_is_control,
  input  logic [7:0]  in_endpoint_address,
  input  logic [7:0]  in_request_type,
  input  logic [7:0]  in_request_code,
  input  logic [15:0] in_setup_value,
  input  logic [15:0] in_requested_length,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_outcome,
  output logic [7:0]  out_data_byte,
  output logic        out_byte_valid,
  output logic        out_last,
  output logic [4:0]  out_actual_length,
  output logic        out_do_connect,
  output logic        out_do_reset_done,
  output logic        out_do_resume,
  output logic [6:0]  out_current_address,
  output logic        out_address_valid,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [usbdr_pkg::REG_W-1:0] cfg_wdata
);
  import usbdr_pkg::*;

  desc_cfg_t dcfg_r;
  cmd_t      front_cmd, back_cmd;
  logic      accept, q_valid, q_pop;

  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcfg_r.vendor_id      <= VENDOR_ID_RST;
      dcfg_r.product_id     <= PRODUCT_ID_RST;
      dcfg_r.device_release <= DEVICE_RELEASE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_VENDOR_ID:      dcfg_r.vendor_id      <= cfg_wdata;
        CFG_PRODUCT_ID:     dcfg_r.product_id     <= cfg_wdata;
        CFG_DEVICE_RELEASE: dcfg_r.device_release <= cfg_wdata;
        default: ;
      endcase
    end
  end

  usbdr_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .accept              (accept),
    .in_func             (in_func),
    .in_port_index       (in_port_index),
    .in_port_status      (in_port_status),
    .in_port_change      (in_port_change),
    .in_port_flags       (in_port_flags),
    .in_target_address   (in_target_address),
    .in_is_control       (in_is_control),
    .in_endpoint_address (in_endpoint_address),
    .in_request_type     (in_request_type),
    .in_request_code     (in_request_code),
    .in_setup_value      (in_setup_value),
    .in_requested_length (in_requested_length),
    .cmd                 (front_cmd)
  );

  usbdr_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_cmd   (front_cmd),
    .full     (full),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_cmd   (back_cmd)
  );

  usbdr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (q_valid),
    .cmd                 (back_cmd),
    .cmd_pop             (q_pop),
    .dcfg                (dcfg_r),
    .empty               (empty),
    .pop                 (pop),
    .out_outcome         (out_outcome),
    .out_data_byte       (out_data_byte),
    .out_byte_valid      (out_byte_valid),
    .out_last            (out_last),
    .out_actual_length   (out_actual_length),
    .out_do_connect      (out_do_connect),
    .out_do_reset_done   (out_do_reset_done),
    .out_do_resume       (out_do_resume),
    .out_current_address (out_current_address),
    .out_address_valid   (out_address_valid)
  );

endmodule

// File: rtl/usbdr_checker.sv
// ---------------------------------------------------------------------------
// usbdr_checker
// Port-level checks on the responder's results, bound to the top level.
// ---------------------------------------------------------------------------
`include "usb_device_request_responder_macros.svh"

module usbdr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  out_outcome,
  input logic        out_byte_valid,
  input logic        out_last,
  input logic [4:0]  out_actual_length,
  input logic        out_do_connect,
  input logic        out_do_reset_done,
  input logic        out_do_resume,
  input logic [6:0]  out_current_address,
  input logic        out_address_valid
);
  import usbdr_pkg::*;

  // descriptor bytes only come from a successful request with a length
  `USBDR_ASSERT_NOW(a_byte_success, clk, rst_n, !empty && out_byte_valid, out_outcome == OUT_SUCCESS && out_actual_length != 5'd0, "descriptor byte without successful request")

  // anything but a descriptor byte is the only result of its request
  `USBDR_ASSERT_NOW(a_single_last, clk, rst_n, !empty && !out_byte_valid, out_last && out_actual_length == 5'd0, "non-byte result not marked last")

  // port requests appear only on port event results
  `USBDR_ASSERT_NOW(a_do_port_only, clk, rst_n, !empty && (out_do_connect || out_do_reset_done || out_do_resume), out_outcome == OUT_PORT_DONE, "port request on a non-event result")

  `USBDR_ASSERT_NOW(a_addr_zero, clk, rst_n, !empty && !out_address_valid, out_current_address == 7'd0, "address shown without a valid address")

  `USBDR_ASSERT_NEXT(a_hold, clk, rst_n, !empty && !pop, !empty && $stable(out_outcome) && $stable(out_last), "pending result dropped or changed")

endmodule

bind usb_device_request_responder usbdr_checker u_usbdr_checker (.*);

// File: dv/ep0_tb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ep0_tb_pkg
// Request/response types, descriptor tables and the response scoreboard
// used by the endpoint-0 responder testbench. The scoreboard keeps its own
// copy of the device address, the port history and the ID registers, and
// works out the full response list of every accepted request.
// ---------------------------------------------------------------------------
package ep0_tb_pkg;
  import usbdr_pkg::*;

  localparam logic FUNC_PORT_EVENT = 1'b0;
  localparam logic FUNC_TRANSFER   = 1'b1;

  localparam logic [15:0] PS_CONN     = 16'd1 << ST_CONN_BIT;
  localparam logic [15:0] PS_ENABLE   = 16'd1 << ST_ENABLE_BIT;
  localparam logic [15:0] PS_RESET    = 16'd1 << ST_RESET_BIT;
  localparam logic [15:0] PS_POWER    = 16'd1 << ST_POWER_BIT;
  localparam logic [15:0] PC_CONN     = 16'd1 << CH_CONN_BIT;
  localparam logic [15:0] PC_RESET    = 16'd1 << CH_RESET_BIT;
  localparam logic [7:0]  PF_RESUMING = 8'd1 << FL_RESUMING_BIT;

  // codes the block does not serve, used to provoke stalls
  localparam logic [7:0] RQ_GET_STATUS = 8'd0;
  localparam logic [7:0] DT_INTERFACE  = 8'd4;

  // bytes 8..13 of the device descriptor come from the ID registers
  localparam logic [7:0] TB_DEV_ROM [18] = '{
    8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd64, 8'd0, 8'd0,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd1};
  localparam logic [7:0] TB_CONF_ROM [18] = '{
    8'd9, 8'd2, 8'd18, 8'd0, 8'd1, 8'd1, 8'd0, 8'h80, 8'd0, 8'd9,
    8'd4, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
  localparam logic [7:0] LANG_DESC [4] = '{8'h04, 8'h03, 8'h09, 8'h04};
  localparam logic [7:0] NAME_DESC [26] = '{
    8'h1a, 8'h03, 8'h48, 8'h00, 8'h65, 8'h00, 8'h6c, 8'h00, 8'h6c, 8'h00,
    8'h6f, 8'h00, 8'h20, 8'h00, 8'h57, 8'h00, 8'h6f, 8'h00, 8'h72, 8'h00,
    8'h6c, 8'h00, 8'h64, 8'h00, 8'h21, 8'h00};

  typedef struct packed {
    logic        func;
    logic [7:0]  port_index;
    logic [15:0] port_status;
    logic [15:0] port_change;
    logic [7:0]  port_flags;
    logic [6:0]  target_address;
    logic        is_control;
    logic [7:0]  endpoint_address;
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [15:0] setup_value;
    logic [15:0] requested_length;
  } ep0_request_t;

  typedef struct packed {
    outcome_t   outcome;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic [4:0] actual_length;
    logic       do_connect;
    logic       do_reset_done;
    logic       do_resume;
    logic [6:0] current_address;
    logic       address_valid;
  } ep0_response_t;

  function automatic string fmt_response(ep0_response_t r);
    return $sformatf(
      "outcome=%0d byte=%02h bv=%0b last=%0b len=%0d con=%0b rstd=%0b res=%0b addr=%0d av=%0b",
      r.outcome, r.data_byte, r.byte_valid, r.last, r.actual_length, r.do_connect,
      r.do_reset_done, r.do_resume, r.current_address, r.address_valid);
  endfunction

  class ep0_response_scoreboard;
    logic [15:0]   vendor_id;
    logic [15:0]   product_id;
    logic [15:0]   device_release;
    logic [6:0]    dev_addr;
    logic          addr_valid;
    logic [15:0]   prev_status;
    logic [7:0]    prev_flags;
    ep0_response_t pending[$];
    int            errors;
    int            checked;
    int            n_events;
    int            n_requests;
    int            n_bytes;

    function new();
      vendor_id      = VENDOR_ID_RST;
      product_id     = PRODUCT_ID_RST;
      device_release = DEVICE_RELEASE_RST;
      dev_addr       = 7'd0;
      addr_valid     = 1'b0;
      prev_status    = 16'd0;
      prev_flags     = 8'd0;
      errors         = 0;
      checked        = 0;
      n_events       = 0;
      n_requests     = 0;
      n_bytes        = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [15:0] value);
      case (idx)
        CFG_VENDOR_ID:      vendor_id = value;
        CFG_PRODUCT_ID:     product_id = value;
        CFG_DEVICE_RELEASE: device_release = value;
        default: ;
      endcase
    endfunction

    // single-result response carrying the address state as it is now
    function ep0_response_t blank(outcome_t oc);
      ep0_response_t e;
      e                 = '0;
      e.outcome         = oc;
      e.last            = 1'b1;
      e.current_address = addr_valid ? dev_addr : 7'd0;
      e.address_valid   = addr_valid;
      return e;
    endfunction

    function logic [7:0] descriptor_byte(desc_t d, int i);
      case (d)
        DESC_DEVICE: begin
          case (i)
            8:       return vendor_id[7:0];
            9:       return vendor_id[15:8];
            10:      return product_id[7:0];
            11:      return product_id[15:8];
            12:      return device_release[7:0];
            13:      return device_release[15:8];
            default: return TB_DEV_ROM[i];
          endcase
        end
        DESC_CONFIG: return TB_CONF_ROM[i];
        DESC_STR0:   return LANG_DESC[i];
        default:     return NAME_DESC[i];
      endcase
    endfunction

    function void note_request(ep0_request_t r);
      ep0_response_t e;
      outcome_t      oc;
      desc_t         sel;
      int            len;
      int            n;

      if (r.func == FUNC_PORT_EVENT) begin
        n_events++;
        if (r.port_index != PORT_ONE) begin
          pending.push_back(blank(OUT_BAD_PORT));
          return;
        end
        e = '0;
        e.do_connect    = !prev_status[ST_POWER_BIT] && r.port_status[ST_POWER_BIT];
        e.do_reset_done = !prev_status[ST_RESET_BIT] && r.port_status[ST_RESET_BIT] &&
                          r.port_status[ST_CONN_BIT];
        e.do_resume     = !prev_flags[FL_RESUMING_BIT] && r.port_flags[FL_RESUMING_BIT] &&
                          r.port_status[ST_CONN_BIT];
        prev_status = r.port_status;
        prev_flags  = r.port_flags;
        if (r.port_change[CH_CONN_BIT]) begin
          addr_valid = 1'b0;
          dev_addr   = 7'd0;
        end
        // reset finished with the port enabled: default address
        if (r.port_change[CH_RESET_BIT] && !r.port_status[ST_RESET_BIT] &&
            r.port_status[ST_ENABLE_BIT]) begin
          dev_addr   = 7'd0;
          addr_valid = 1'b1;
        end
        oc = OUT_PORT_DONE;
        pending.push_back(blank(oc) | e);
        return;
      end

      n_requests++;
      sel = DESC_NONE;
      len = 0;
      if (!addr_valid || r.target_address != dev_addr) begin
        oc = OUT_NOT_ADDR;
      end else if (!r.is_control) begin
        oc = OUT_NOT_CTRL;
      end else if (r.endpoint_address[6:0] != 7'd0) begin
        oc = OUT_STALL;
      end else if (r.request_type == RT_STD_OUT_DEV && r.request_code == RQ_SET_ADDRESS) begin
        if (r.setup_value > 16'd127) begin
          oc = OUT_STALL;
        end else begin
          dev_addr   = r.setup_value[6:0];
          addr_valid = 1'b1;
          oc         = OUT_SUCCESS;
        end
      end else if (r.request_type == RT_STD_OUT_DEV &&
                   (r.request_code == RQ_SET_CONFIGURATION ||
                    r.request_code == RQ_SET_INTERFACE)) begin
        oc = OUT_SUCCESS;
      end else begin
        if (r.request_type == RT_STD_IN_DEV && r.request_code == RQ_GET_DESC) begin
          if (r.setup_value[15:8] == DT_DEVICE) begin
            sel = DESC_DEVICE;
            len = LEN_DEVICE;
          end else if (r.setup_value[15:8] == DT_CONFIG) begin
            sel = DESC_CONFIG;
            len = LEN_CONFIG;
          end else if (r.setup_value[15:8] == DT_STRING && r.setup_value[7:0] == 8'd0) begin
            sel = DESC_STR0;
            len = LEN_STR0;
          end else if (r.setup_value[15:8] == DT_STRING && r.setup_value[7:0] == 8'd1) begin
            sel = DESC_STR1;
            len = LEN_STR1;
          end
        end
        oc = (sel == DESC_NONE) ? OUT_STALL : OUT_SUCCESS;
      end

      n = (r.requested_length < len) ? int'(r.requested_length) : len;
      if (sel == DESC_NONE || n == 0) begin
        pending.push_back(blank(oc));
        return;
      end
      // one response per descriptor byte, clamped to wLength
      for (int i = 0; i < n; i++) begin
        e               = blank(OUT_SUCCESS);
        e.data_byte     = descriptor_byte(sel, i);
        e.byte_valid    = 1'b1;
        e.last          = (i == n - 1);
        e.actual_length = 5'(n);
        pending.push_back(e);
        n_bytes++;
      end
    endfunction

    function void report(string what, string detail);
      errors++;
      if (errors <= 10) $display("MISMATCH %s: %s", what, detail);
    endfunction

    function void check_response(ep0_response_t got);
      ep0_response_t want;
      string         bad;

      if (pending.size() == 0) begin
        report("response with nothing pending", fmt_response(got));
        return;
      end
      want = pending.pop_front();
      checked++;
      bad = "";
      if (got.outcome !== want.outcome) bad = {bad, " outcome"};
      if (got.data_byte !== want.data_byte) bad = {bad, " data_byte"};
      if (got.byte_valid !== want.byte_valid) bad = {bad, " byte_valid"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (got.actual_length !== want.actual_length) bad = {bad, " actual_length"};
      if (got.do_connect !== want.do_connect) bad = {bad, " do_connect"};
      if (got.do_reset_done !== want.do_reset_done) bad = {bad, " do_reset_done"};
      if (got.do_resume !== want.do_resume) bad = {bad, " do_resume"};
      if (got.current_address !== want.current_address) bad = {bad, " current_address"};
      if (got.address_valid !== want.address_valid) bad = {bad, " address_valid"};
      if (bad != "")
        report({"field", bad}, {"exp ", fmt_response(want), " | got ", fmt_response(got)});
    endfunction
  endclass

endpackage

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the endpoint-0 responder. A directed enumeration run walks
// port events and every request kind; random traffic follows over several
// ID register settings. Each popped response is checked against the
// scoreboard; input bursts and output stall patterns vary throughout.
// ---------------------------------------------------------------------------
module tb_top;
  import usbdr_pkg::*;
  import ep0_tb_pkg::*;

  localparam int LONG_HOLD    = 200;
  localparam int PHASE_ITEMS  = 38;

  typedef enum {RX_STEADY, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        in_func = 1'b0;
  logic [7:0]  in_port_index = '0;
  logic [15:0] in_port_status = '0;
  logic [15:0] in_port_change = '0;
  logic [7:0]  in_port_flags = '0;
  logic [6:0]  in_target_address = '0;
  logic        in_is_control = 1'b0;
  logic [7:0]  in_endpoint_address = '0;
  logic [7:0]  in_request_type = '0;
  logic [7:0]  in_request_code = '0;
  logic [15:0] in_setup_value = '0;
  logic [15:0] in_requested_length = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [2:0]  out_outcome;
  logic [7:0]  out_data_byte;
  logic        out_byte_valid;
  logic        out_last;
  logic [4:0]  out_actual_length;
  logic        out_do_connect;
  logic        out_do_reset_done;
  logic        out_do_resume;
  logic [6:0]  out_current_address;
  logic        out_address_valid;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  ep0_response_scoreboard sb = new();

  int          burst_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left = 0;
  int          mode_left = 0;
  rx_pattern_t pop_mode = RX_STEADY;

  usb_device_request_responder uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .push                (push),
    .full                (full),
    .in_func             (in_func),
    .in_port_index       (in_port_index),
    .in_port_status      (in_port_status),
    .in_port_change      (in_port_change),
    .in_port_flags       (in_port_flags),
    .in_target_address   (in_target_address),
    .in_is_control       (in_is_control),
    .in_endpoint_address (in_endpoint_address),
    .in_request_type     (in_request_type),
    .in_request_code     (in_request_code),
    .in_setup_value      (in_setup_value),
    .in_requested_length (in_requested_length),
    .empty               (empty),
    .pop                 (pop),
    .out_outcome         (out_outcome),
    .out_data_byte       (out_data_byte),
    .out_byte_valid      (out_byte_valid),
    .out_last            (out_last),
    .out_actual_length   (out_actual_length),
    .out_do_connect      (out_do_connect),
    .out_do_reset_done   (out_do_reset_done),
    .out_do_resume       (out_do_resume),
    .out_current_address (out_current_address),
    .out_address_valid   (out_address_valid),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---- request builders ----
  function automatic ep0_request_t noise();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(ep0_request_t)-1:0];
  endfunction

  function automatic ep0_request_t port_evt(logic [7:0] idx, logic [15:0] status,
                                            logic [15:0] change, logic [7:0] flags);
    ep0_request_t r;
    r             = noise();
    r.func        = FUNC_PORT_EVENT;
    r.port_index  = idx;
    r.port_status = status;
    r.port_change = change;
    r.port_flags  = flags;
    return r;
  endfunction

  // well-formed control request to whatever address the device holds now
  function automatic ep0_request_t ctl_req(logic [7:0] rtype, logic [7:0] rcode,
                                           logic [15:0] value, logic [15:0] length);
    ep0_request_t r;
    r                  = noise();
    r.func             = FUNC_TRANSFER;
    r.target_address   = sb.dev_addr;
    r.is_control       = 1'b1;
    r.endpoint_address = {r.endpoint_address[7], 7'd0};
    r.request_type     = rtype;
    r.request_code     = rcode;
    r.setup_value      = value;
    r.requested_length = length;
    return r;
  endfunction

  function automatic ep0_request_t random_request();
    ep0_request_t r;
    int           pick;
    logic [7:0]   dtype;
    logic [7:0]   didx;
    logic [15:0]  want;

    pick = $urandom_range(0, 99);
    // no address: mostly re-enumerate with a completed port reset
    if (!sb.addr_valid && pick < 60)
      return port_evt(PORT_ONE, (16'($urandom) & ~PS_RESET) | PS_POWER | PS_CONN | PS_ENABLE,
                      (16'($urandom) & ~PC_CONN) | PC_RESET, 8'($urandom));
    if (pick < 15) begin
      r = port_evt(($urandom_range(0, 7) == 0) ? 8'($urandom) : PORT_ONE,
                   16'($urandom), 16'($urandom), 8'($urandom));
      if ($urandom_range(0, 3) != 0) r.port_change[CH_CONN_BIT] = 1'b0;
      return r;
    end

    want = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      case ($urandom_range(0, 4))
        0:       dtype = DT_DEVICE;
        1:       dtype = DT_CONFIG;
        2, 3:    dtype = DT_STRING;
        default: dtype = 8'($urandom);
      endcase
      didx = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      r = ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {dtype, didx}, want);
    end else if (pick < 60) begin
      r = ctl_req(RT_STD_OUT_DEV, RQ_SET_ADDRESS,
                  ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 127)),
                  want);
    end else if (pick < 75) begin
      r = ctl_req(RT_STD_OUT_DEV,
                  ($urandom_range(0, 1) != 0) ? RQ_SET_CONFIGURATION : RQ_SET_INTERFACE,
                  16'($urandom), want);
    end else begin
      r = ctl_req(($urandom_range(0, 1) != 0) ? 8'($urandom) : RT_STD_IN_DEV,
                  ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                  16'($urandom), want);
    end

    pick = $urandom_range(0, 99);
    if (pick < 6)       r.target_address = 7'($urandom);
    else if (pick < 12) r.is_control = 1'b0;
    else if (pick < 18) r.endpoint_address = 8'($urandom);
    return r;
  endfunction

  // ---- drivers ----
  task automatic send(input ep0_request_t r);
    int gap;
    in_func             <= r.func;
    in_port_index       <= r.port_index;
    in_port_status      <= r.port_status;
    in_port_change      <= r.port_change;
    in_port_flags       <= r.port_flags;
    in_target_address   <= r.target_address;
    in_is_control       <= r.is_control;
    in_endpoint_address <= r.endpoint_address;
    in_request_type     <= r.request_type;
    in_request_code     <= r.request_code;
    in_setup_value      <= r.setup_value;
    in_requested_length <= r.requested_length;
    push                <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(r);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // stop sending and let every pending response come out
  task automatic drain();
    push <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write enable stays high across the three back-to-back writes
  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_register(idx, value);
  endtask

  task automatic write_regs(input logic [15:0] vid, input logic [15:0] pid,
                            input logic [15:0] rel);
    write_reg(CFG_VENDOR_ID, vid);
    write_reg(CFG_PRODUCT_ID, pid);
    write_reg(CFG_DEVICE_RELEASE, rel);
    cfg_wr_en <= 1'b0;
  endtask

  // ---- response side ----
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop       <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      pop        <= 1'b0;
      hold_left  <= LONG_HOLD;
      hold_taken <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        pop_mode  <= rx_pattern_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(16, 96);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (pop_mode)
        RX_STEADY:   pop <= 1'b1;
        RX_MOSTLY:   pop <= ($urandom_range(0, 3) != 0);
        RX_SPARSE:   pop <= ($urandom_range(0, 3) == 0);
        default:     pop <= (mode_left % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    ep0_response_t got;
    if (rst_n && pop && !empty) begin
      got.outcome         = outcome_t'(out_outcome);
      got.data_byte       = out_data_byte;
      got.byte_valid      = out_byte_valid;
      got.last            = out_last;
      got.actual_length   = out_actual_length;
      got.do_connect      = out_do_connect;
      got.do_reset_done   = out_do_reset_done;
      got.do_resume       = out_do_resume;
      got.current_address = out_current_address;
      got.address_valid   = out_address_valid;
      sb.check_response(got);
    end
  end

  // ---- stimulus ----
  initial begin : stimulus
    ep0_request_t r;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // enumeration walk with the reset ID values
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'd18));
    send(port_evt(8'd0, PS_POWER, 16'd0, 8'd0));
    send(port_evt(8'hff, PS_POWER, 16'd0, 8'd0));
    send(port_evt(PORT_ONE, PS_POWER, 16'd0, 8'd0));
    send(port_evt(PORT_ONE, PS_POWER | PS_CONN, PC_CONN, 8'd0));
    send(port_evt(PORT_ONE, PS_POWER | PS_CONN | PS_RESET, 16'd0, 8'd0));
    send(port_evt(PORT_ONE, PS_POWER | PS_CONN | PS_ENABLE, PC_RESET, 8'd0));
    send(port_evt(PORT_ONE, PS_POWER | PS_CONN | PS_ENABLE, 16'd0, PF_RESUMING));
    r = ctl_req(RT_STD_OUT_DEV, RQ_SET_CONFIGURATION, 16'd1, 16'd0);
    r.is_control = 1'b0;
    send(r);
    r = ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'd18);
    r.endpoint_address = 8'h81;
    send(r);
    r.endpoint_address = 8'h80;
    r.requested_length = 16'hffff;
    send(r);
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_CONFIG, 8'd0}, 16'd5));
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_STRING, 8'd0}, 16'd4));
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_STRING, 8'd1}, 16'd26));
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_STRING, 8'd2}, 16'd26));
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_INTERFACE, 8'd0}, 16'd9));
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_DEVICE, 8'hff}, 16'd0));
    send(ctl_req(RT_STD_OUT_DEV, RQ_SET_CONFIGURATION, 16'hffff, 16'hffff));
    send(ctl_req(RT_STD_OUT_DEV, RQ_SET_INTERFACE, 16'd0, 16'd0));
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_STATUS, 16'd0, 16'd2));
    send(ctl_req(RT_STD_OUT_DEV, RQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'd18));
    send(ctl_req(RT_STD_OUT_DEV, RQ_SET_ADDRESS, 16'h0080, 16'd0));
    send(ctl_req(RT_STD_OUT_DEV, RQ_SET_ADDRESS, 16'hffff, 16'd0));
    send(ctl_req(RT_STD_OUT_DEV, RQ_SET_ADDRESS, 16'h007f, 16'd0));
    r = ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'd13);
    r.target_address = 7'd0;
    send(r);
    send(ctl_req(RT_STD_IN_DEV, RQ_GET_DESC, {DT_DEVICE, 8'd0}, 16'd13));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       write_regs(16'h0000, 16'h0000, 16'h0000);
        1:       write_regs(16'hffff, 16'hffff, 16'hffff);
        default: write_regs(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
      // output side backs off while input keeps coming, so the queue fills
      if (ph == 1) hold_req <= 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) send(random_request());
      drain();
    end

    repeat (20) @(posedge clk);
    $display("summary: %0d port events, %0d transfer requests, %0d responses checked",
             sb.n_events, sb.n_requests, sb.checked);
    $display("summary: %0d descriptor bytes over 5 ID settings, %0d mismatches",
             sb.n_bytes, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
